### hw/rtl/trace_ring_buffer_with_overflow_marker_defines.svh
// ---------------------------------------------------------------------------
// trace ring buffer assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while in reset
// ---------------------------------------------------------------------------
`ifndef TRACE_RING_BUFFER_WITH_OVERFLOW_MARKER_DEFINES_SVH
`define TRACE_RING_BUFFER_WITH_OVERFLOW_MARKER_DEFINES_SVH

// same-cycle implication
`define TRB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/trb_pkg.sv
// ---------------------------------------------------------------------------
// trace ring buffer package
// word types, operation codes, register indexes and size defaults
// ---------------------------------------------------------------------------
package trb_pkg;

	localparam int unsigned TRB_CAPACITY  = 256;
	localparam int unsigned READ_INDEX_W  = 8;
	localparam int unsigned ENTRY_COUNT_W = 9;
	localparam int unsigned CFG_INDEX_W   = 8;
	localparam int unsigned CFG_DATA_W    = 16;

	typedef enum logic [1:0] {
		OP_EMIT  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_e;

	localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_KIND   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_SUBSYS = 8'd1;

	typedef struct packed {
		logic [1:0]              kind;
		logic [15:0]             rec_kind;
		logic [7:0]              rec_subsystem;
		logic [63:0]             rec_payload;
		logic [READ_INDEX_W-1:0] read_index;
	} in_word_t;

	typedef struct packed {
		logic [63:0]              emitted_sequence;
		logic                     found;
		logic [15:0]              out_kind;
		logic [7:0]               out_subsystem;
		logic [63:0]              out_payload;
		logic [63:0]              out_sequence;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic [63:0]              dropped_total;
		logic [63:0]              next_seq;
		logic                     marker_written;
	} out_word_t;

	typedef struct packed {
		logic [15:0] kind;
		logic [7:0]  subsystem;
		logic [63:0] payload;
		logic [63:0] seq_no;
	} record_t;

	// per-cycle status from the control unit to the result stage
	typedef struct packed {
		logic                     marker_step;
		logic                     found;
		logic [63:0]              emitted_sequence;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic [63:0]              dropped_total;
		logic [63:0]              next_seq;
	} status_t;

endpackage

### hw/rtl/trb_ram.sv
// ---------------------------------------------------------------------------
// trace record memory
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module trb_ram
	import trb_pkg::*;
#(
	parameter int unsigned CAPACITY = TRB_CAPACITY,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  record_t       wdata,
	input  logic [AW-1:0] raddr,
	output record_t       rdata
);

	record_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/trb_ctrl.sv
// ---------------------------------------------------------------------------
// trace ring buffer control
// pointers, counters, overflow flag and per-item write/read decisions
// ---------------------------------------------------------------------------
`include "trace_ring_buffer_with_overflow_marker_defines.svh"

module trb_ctrl
	import trb_pkg::*;
#(
	parameter int unsigned CAPACITY = TRB_CAPACITY,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  in_word_t      item,
	input  logic [15:0]   marker_kind,
	input  logic [7:0]    marker_subsys,
	output logic          we,
	output logic [AW-1:0] waddr,
	output record_t       wdata,
	output logic [AW-1:0] raddr,
	output status_t       status
);

	localparam int unsigned CNTW = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CNTW > READ_INDEX_W) ? CNTW : READ_INDEX_W;
	localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

	logic [AW-1:0]   wp_q, wp_d;
	logic [CNTW-1:0] held_q, held_d;
	logic [63:0]     seq_q, seq_d;
	logic [63:0]     dropped_q, dropped_d;
	logic            ovf_q, ovf_d;

	logic            full;
	logic            marker_step;
	logic            hit;
	logic [AW-1:0]   start_idx;

	assign full        = (held_q == CAP_CNT);
	assign marker_step = valid && (item.kind == OP_EMIT) && full && !ovf_q;
	assign hit         = CMPW'(item.read_index) < CMPW'(held_q);
	// oldest entry sits at the write pointer once the ring has wrapped
	assign start_idx   = full ? wp_q : '0;

	always_comb begin
		wp_d      = wp_q;
		held_d    = held_q;
		seq_d     = seq_q;
		dropped_d = dropped_q;
		ovf_d     = ovf_q;
		we        = 1'b0;
		waddr     = wp_q;
		wdata     = '0;
		raddr     = start_idx + AW'(item.read_index);
		status    = '0;
		if (marker_step) begin
			we        = 1'b1;
			wdata     = '{kind: marker_kind, subsystem: marker_subsys,
				payload: dropped_q + 64'd1, seq_no: seq_q};
			wp_d      = wp_q + 1'b1;
			seq_d     = seq_q + 64'd1;
			dropped_d = dropped_q + 64'd1;
			ovf_d     = 1'b1;
		end else if (valid) begin
			unique case (item.kind)
				OP_EMIT: begin
					we     = 1'b1;
					wdata  = '{kind: item.rec_kind, subsystem: item.rec_subsystem,
						payload: item.rec_payload, seq_no: seq_q};
					status.emitted_sequence = seq_q;
					wp_d   = wp_q + 1'b1;
					seq_d  = seq_q + 64'd1;
					if (full) begin
						dropped_d = dropped_q + 64'd1;
					end else begin
						held_d = held_q + 1'b1;
					end
				end
				OP_READ: begin
					status.found = hit;
				end
				OP_CLEAR: begin
					wp_d      = '0;
					held_d    = '0;
					seq_d     = 64'd1;
					dropped_d = '0;
					ovf_d     = 1'b0;
				end
				default: begin
					// unused code: status only
				end
			endcase
		end
		status.marker_step   = marker_step;
		status.entry_count   = ENTRY_COUNT_W'(held_d);
		status.dropped_total = dropped_d;
		status.next_seq      = seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			held_q    <= '0;
			seq_q     <= 64'd1;
			dropped_q <= '0;
			ovf_q     <= 1'b0;
		end else if (valid) begin
			wp_q      <= wp_d;
			held_q    <= held_d;
			seq_q     <= seq_d;
			dropped_q <= dropped_d;
			ovf_q     <= ovf_d;
		end
	end

	`TRB_ASSERT_NOW(a_held_range, 1'b1, held_q <= CAP_CNT, "held count above capacity")
	`TRB_ASSERT_NOW(a_wp_tracks_fill, held_q < CAP_CNT, wp_q == AW'(held_q),
		"write pointer off fill count before wrap")
	`TRB_ASSERT_NOW(a_no_drop_before_marker, !ovf_q, dropped_q == 64'd0,
		"records dropped without overflow marker")
	`TRB_ASSERT_NEXT(a_marker_sets_flag, marker_step, ovf_q && full,
		"marker step did not set overflow flag")

endmodule

### hw/rtl/trace_ring_buffer_with_overflow_marker.sv
// ---------------------------------------------------------------------------
// trace ring buffer with overflow marker
// overwriting ring of trace records with a one-time overflow marker
// ---------------------------------------------------------------------------
// done is registered: the word enters s1 at the accepting edge and then sets
// done_s2; an emit that inserts the overflow marker holds s1 (busy is high)
// throughput: one word per cycle while busy is low; the marker emit holds the
// word in s1 while busy is high, set by the single write port of the ring
// done is a one-cycle strobe with no back-pressure from the receiver
// reset clears pointers, counters, flag and marker codes (next sequence starts at 1); ring contents kept
module trace_ring_buffer_with_overflow_marker
	import trb_pkg::*;
#(
	parameter int unsigned CAPACITY = TRB_CAPACITY,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  in_word_t               item,
	output logic                   done,
	output out_word_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic        valid_s1;
	in_word_t    item_s1;
	logic        marker_q;
	logic [15:0] mkind_q;
	logic [7:0]  msubsys_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	record_t       wdata;
	record_t       rdata;
	status_t       status;

	logic          done_s2;
	status_t       stat_s2;
	logic          marker_s2;

	logic accept;
	logic item_done;

	assign busy      = valid_s1 && status.marker_step;
	assign accept    = start && !busy;
	assign item_done = valid_s1 && !status.marker_step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mkind_q   <= '0;
			msubsys_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MARKER_KIND) begin
				mkind_q <= cfg_data[15:0];
			end else if (cfg_index == CFG_MARKER_SUBSYS) begin
				msubsys_q <= cfg_data[7:0];
			end
		end
	end

	// the word stays in s1 over the marker cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			marker_q <= 1'b0;
		end else begin
			valid_s1 <= accept || busy;
			if (busy) begin
				marker_q <= 1'b1;
			end else if (item_done) begin
				marker_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	trb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_s1),
		.item         (item_s1),
		.marker_kind  (mkind_q),
		.marker_subsys(msubsys_q),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.raddr        (raddr),
		.status       (status)
	);

	trb_ram #(.CAPACITY(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= item_done;
		end
	end

	always_ff @(posedge clk) begin
		stat_s2   <= status;
		marker_s2 <= marker_q;
	end

	assign done = done_s2;

	always_comb begin
		result                  = '0;
		result.emitted_sequence = stat_s2.emitted_sequence;
		result.found            = stat_s2.found;
		result.entry_count      = stat_s2.entry_count;
		result.dropped_total    = stat_s2.dropped_total;
		result.next_seq         = stat_s2.next_seq;
		result.marker_written   = marker_s2;
		if (stat_s2.found) begin
			result.out_kind      = rdata.kind;
			result.out_subsystem = rdata.subsystem;
			result.out_payload   = rdata.payload;
			result.out_sequence  = rdata.seq_no;
		end
	end

endmodule
